[design/assert_macros.svh]
// Assertion macros shared by the depth centroid block.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that trig implies prop in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);
`endif

[design/dcpl_pkg.sv]
// Package of the depth centroid path length block: widths, constants, records.
// No dependencies.
package dcpl_pkg;
  localparam int unsigned WindowFrames = 10;
  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned DepthScale   = 100;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 11;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;
  localparam logic [10:0] ResetWidth  = 11'd640;
  localparam logic [10:0] ResetHeight = 11'd480;
  localparam int unsigned DispW   = 22;
  localparam int unsigned DistW   = 19;
  localparam int unsigned CentW   = 18;
  localparam int unsigned SumPosW = 36;
  localparam int unsigned SumDepW = 40;
  localparam int unsigned CountW  = 26;
  localparam logic [DispW-1:0] DispMax = {DispW{1'b1}};

  // End-of-frame totals handed from front to back
  typedef struct packed {
    logic [SumPosW-1:0] sum_col;
    logic [SumPosW-1:0] sum_row;
    logic [SumDepW-1:0] sum_dep;
    logic [CountW-1:0]  count;
  } frame_sums_t;
endpackage

[design/dcpl_if.sv]
// Valid/ready stream interface used by all channels of the block.
// Depends on nothing; payload width is a parameter.
interface dcpl_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/depth_centroid_path_length_core.sv]
// Depth centroid path length: accepts one depth pixel per cycle unless a frame end stalls.
// A frame end hands its sums to a two-entry queue; the back part takes one frame at a time
// through three divides, a square sum and a square root, then updates the window.
// The result of a frame follows its last pixel through the queue and the back part; a frame
// end stalls the input while the queue is full.
// Reset (rst_ni low, asynchronous) clears counters, sums and window; size 640x480.
module depth_centroid_path_length_core #(
  parameter int unsigned WINDOW_FRAMES = dcpl_pkg::WindowFrames,
  parameter int unsigned MAX_WIDTH     = dcpl_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT    = dcpl_pkg::MaxHeight
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dcpl_if.sink   in_if,
  dcpl_if.source out_if,
  dcpl_if.sink   cfg_if
);
  logic [10:0] w_q, h_q;
  logic sv, sr, qv, qr;
  dcpl_pkg::frame_sums_t sd, qd;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= dcpl_pkg::ResetWidth;
      h_q <= dcpl_pkg::ResetHeight;
    end else if (cfg_if.valid) begin
      if (cfg_if.data[11] == dcpl_pkg::RegFrameWidth) w_q <= cfg_if.data[10:0];
      else h_q <= cfg_if.data[10:0];
    end
  end

  dcpl_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .depth_i(in_if.data),
    .width_i(w_q), .height_i(h_q),
    .sums_valid_o(sv), .sums_ready_i(sr), .sums_o(sd)
  );

  dcpl_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(sv), .wr_ready_o(sr), .wr_data_i(sd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  dcpl_back #(.WINDOW_FRAMES(WINDOW_FRAMES)) u_back (
    .clk_i, .rst_ni,
    .sums_valid_i(qv), .sums_ready_o(qr), .sums_i(qd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .disp_o(out_if.data[25:4]), .frames_o(out_if.data[3:0])
  );
endmodule

[design/dcpl_front.sv]
// Front: raster position tracking and per-frame sums.
// Depends on dcpl_pkg.
module dcpl_front #(
  parameter int unsigned MAX_WIDTH  = dcpl_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = dcpl_pkg::MaxHeight
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           depth_i,
  input  logic [10:0]           width_i,
  input  logic [10:0]           height_i,
  output logic                  sums_valid_o,
  input  logic                  sums_ready_i,
  output dcpl_pkg::frame_sums_t sums_o
);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 1) > 11 ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int unsigned PH = $clog2(MAX_HEIGHT + 1) > 11 ? $clog2(MAX_HEIGHT + 1) : 11;
  localparam int unsigned XW = PW > PH ? PW : PH;

  logic [PW-1:0] col_q, col_d, w_eff;
  logic [PH-1:0] row_q, row_d, h_eff;
  dcpl_pkg::frame_sums_t acc_q, acc_d;
  logic [XW:0] wc, hc;
  logic row_end, frame_end, fire;

  always_comb begin
    wc = XW'(width_i) == '0 ? (XW+1)'(1) : (XW+1)'(width_i);
    if (wc > (XW+1)'(MAX_WIDTH)) wc = (XW+1)'(MAX_WIDTH);
    hc = XW'(height_i) == '0 ? (XW+1)'(1) : (XW+1)'(height_i);
    if (hc > (XW+1)'(MAX_HEIGHT)) hc = (XW+1)'(MAX_HEIGHT);
    if (height_i == '0) hc = (XW+1)'(1);
    if (width_i == '0) wc = (XW+1)'(1);
  end
  assign w_eff = PW'(wc);
  assign h_eff = PH'(hc);

  // Stall only when a frame ends and the queue is full
  assign row_end    = ({1'b0, col_q} + 1'b1) >= {1'b0, w_eff};
  assign frame_end  = row_end && (({1'b0, row_q} + 1'b1) >= {1'b0, h_eff});
  assign in_ready_o = !frame_end || sums_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    acc_d = acc_q;
    col_d = col_q;
    row_d = row_q;
    if (depth_i != '0) begin
      acc_d.sum_col = acc_q.sum_col + dcpl_pkg::SumPosW'(col_q);
      acc_d.sum_row = acc_q.sum_row + dcpl_pkg::SumPosW'(row_q);
      acc_d.sum_dep = acc_q.sum_dep + dcpl_pkg::SumDepW'(depth_i);
      acc_d.count   = acc_q.count + 1'b1;
    end
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  assign sums_o       = acc_d;
  assign sums_valid_o = in_valid_i && frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      acc_q <= '0;
    end else if (fire) begin
      col_q <= col_d;
      row_q <= row_d;
      acc_q <= frame_end ? '0 : acc_d;
    end
  end
endmodule

[design/dcpl_fifo.sv]
// Two-entry queue between front and back.
// Depends on dcpl_pkg.
`include "assert_macros.svh"
module dcpl_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  dcpl_pkg::frame_sums_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output dcpl_pkg::frame_sums_t rd_data_o
);
  dcpl_pkg::frame_sums_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2, "queue count overflow")
  `ASSERT_NEXT(a_ptr_gap, clk_i, rst_ni, 1'b1, (cnt_q == 2'd1) == (wp_q != rp_q),
    "queue pointers disagree with count")
endmodule

[design/dcpl_back.sv]
// Back: centroid divide, distance square root, window ring and result register.
// Depends on dcpl_pkg.
`include "assert_macros.svh"
module dcpl_back #(
  parameter int unsigned WINDOW_FRAMES = dcpl_pkg::WindowFrames
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sums_valid_i,
  output logic                  sums_ready_o,
  input  dcpl_pkg::frame_sums_t sums_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [21:0]           disp_o,
  output logic [3:0]            frames_o
);
  localparam int unsigned Slots = WINDOW_FRAMES - 1;
  localparam int unsigned SW    = Slots > 1 ? $clog2(Slots) : 1;
  localparam int unsigned FW    = $clog2(WINDOW_FRAMES + 1);
  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 33;
  localparam int unsigned SqW   = 38;
  localparam int unsigned RsW   = 32;
  localparam int unsigned CW    = dcpl_pkg::CentW;
  localparam int unsigned DistW_l = dcpl_pkg::DistW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] st_q;
  dcpl_pkg::frame_sums_t s_q;
  logic [1:0]      ax_q;
  logic [5:0]      it_q;
  logic [NumW-1:0] rem_q, quo_q;
  logic [DenW-1:0] den;
  logic [NumW-1:0] num;
  logic [NumW:0]   trial;
  logic [CW-1:0]   c_q [3];
  logic [CW-1:0]   p_q [3];
  logic [SqW-1:0]  sq_q;
  logic [CW-1:0]   dd;
  logic [SqW-1:0]  rv_q, rres_q, rbit_q;
  logic [DistW_l-1:0] ring_q [Slots];
  logic [SW-1:0]   ptr_q;
  logic [FW-1:0]   held_q;
  logic [RsW-1:0]  rsum_q;
  logic            ov_q;
  logic [21:0]     disp_q;
  logic [3:0]      fr_q;

  assign sums_ready_o = st_q == StIdle;
  assign out_valid_o  = ov_q;
  assign disp_o       = disp_q;
  assign frames_o     = fr_q;

  always_comb begin
    case (ax_q)
      2'd0: num = {{(NumW - dcpl_pkg::SumPosW - 8){1'b0}}, s_q.sum_col, 8'd0};
      2'd1: num = {{(NumW - dcpl_pkg::SumPosW - 8){1'b0}}, s_q.sum_row, 8'd0};
      default: num = {s_q.sum_dep, 8'd0};
    endcase
    den = ax_q == 2'd2 ? DenW'(s_q.count) * DenW'(dcpl_pkg::DepthScale)
                       : DenW'(s_q.count);
    trial = {rem_q[NumW-2:0], num[6'(NumW-1) - it_q]} - {{(NumW-DenW+1){1'b0}}, den};
    dd = (c_q[ax_q] >= p_q[ax_q]) ? c_q[ax_q] - p_q[ax_q] : p_q[ax_q] - c_q[ax_q];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && sums_valid_i) s_q <= sums_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ax_q   <= '0;
      it_q   <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      sq_q   <= '0;
      rv_q   <= '0;
      rres_q <= '0;
      rbit_q <= '0;
      ptr_q  <= '0;
      held_q <= '0;
      rsum_q <= '0;
      ov_q   <= 1'b0;
      disp_q <= '0;
      fr_q   <= '0;
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= '0;
        p_q[k] <= '0;
      end
    end else begin
      if (st_q == StOut && (!ov_q || out_ready_i)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (sums_valid_i) begin
            st_q  <= StDiv;
            ax_q  <= '0;
            it_q  <= '0;
            rem_q <= '0;
            quo_q <= '0;
          end
        end
        StDiv: begin
          // one quotient bit a cycle, restoring
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0];
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NumW-2:0], num[6'(NumW-1) - it_q]};
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == 6'(NumW-1)) begin
            c_q[ax_q] <= s_q.count == '0 ? '0
                : CW'(trial[NumW] ? {quo_q[NumW-2:0], 1'b0} : {quo_q[NumW-2:0], 1'b1});
            it_q  <= '0;
            rem_q <= '0;
            quo_q <= '0;
            if (ax_q == 2'd2) begin
              ax_q <= '0;
              sq_q <= '0;
              st_q <= StSq;
            end else begin
              ax_q <= ax_q + 1'b1;
            end
          end
        end
        StSq: begin
          sq_q <= sq_q + SqW'(dd) * SqW'(dd);
          if (ax_q == 2'd2) begin
            st_q <= StRoot;
            it_q <= '0;
          end else begin
            ax_q <= ax_q + 1'b1;
          end
        end
        StRoot: begin
          if (it_q == '0) begin
            rv_q   <= sq_q;
            rres_q <= '0;
            rbit_q <= SqW'(1) << (SqW - 2);
            it_q   <= 6'd1;
          end else if (rbit_q == '0) begin
            st_q <= StUpd;
          end else begin
            if (rv_q >= rres_q + rbit_q) begin
              rv_q   <= rv_q - (rres_q + rbit_q);
              rres_q <= (rres_q >> 1) + rbit_q;
            end else begin
              rres_q <= rres_q >> 1;
            end
            rbit_q <= rbit_q >> 2;
          end
        end
        default: begin
          if (st_q == StUpd) begin
            logic [RsW-1:0] ns;
            logic [FW-1:0]  nh;
            ns = rsum_q;
            nh = held_q;
            if (held_q != '0) begin
              if (held_q - 1'b1 >= FW'(Slots))
                ns = ns - RsW'(ring_q[ptr_q]);
              ns = ns + RsW'(rres_q[DistW_l-1:0]);
              ptr_q <= (32'(ptr_q) + 1 >= Slots) ? '0 : ptr_q + 1'b1;
            end
            if (held_q < FW'(WINDOW_FRAMES)) nh = held_q + 1'b1;
            rsum_q <= ns;
            held_q <= nh;
            for (int k = 0; k < 3; k++) p_q[k] <= c_q[k];
            st_q <= StOut;
          end else if (!ov_q || out_ready_i) begin
            // load the result only once the previous one has left
            disp_q <= held_q >= FW'(2) ? (rsum_q > RsW'(dcpl_pkg::DispMax) ? dcpl_pkg::DispMax
                                                                        : 22'(rsum_q)) : '0;
            fr_q <= 4'(held_q);
            st_q <= StIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StUpd && held_q != '0) ring_q[ptr_q] <= rres_q[DistW_l-1:0];
  end

  `ASSERT_CLK(a_ptr_range, clk_i, rst_ni, 32'(ptr_q) < Slots, "ring pointer out of range")
  `ASSERT_CLK(a_held_range, clk_i, rst_ni, held_q <= FW'(WINDOW_FRAMES), "frames held too big")
  `ASSERT_NEXT(a_out_load, clk_i, rst_ni, st_q == StUpd, st_q == StOut,
    "update not followed by output")
endmodule

[tb/sv/depth_centroid_path_length_core_tb.sv]
// Testbench of depth_centroid_path_length_core: random pixel streams, frame sizes and stalls.
// Each result is checked against a behavioral predictor of the block, or against the table for typed rows.
// Depends on dcpl_pkg, dcpl_if and the core.
module depth_centroid_path_length_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = dcpl_pkg::WindowFrames - 1;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic [dcpl_pkg::DispW-1:0] displacement;
    logic [3:0]                 frames;
  } path_res_t;

  typedef struct {
    logic [15:0]                depth;
    bit                         typed;
    logic [dcpl_pkg::DispW-1:0] disp;
    logic [3:0]                 frames;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  dcpl_if #(.W(16))                                    in_if ();
  dcpl_if #(.W(dcpl_pkg::DispW + 4))                   out_if ();
  dcpl_if #(.W(dcpl_pkg::CfgIdxW + dcpl_pkg::CfgDataW)) cfg_if ();

  depth_centroid_path_length_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // predictor state
  int unsigned       cfg_w, cfg_h, col, row;
  longint unsigned   s_col, s_row, s_dep, n_pix, prev_c[3], run_sum;
  int unsigned       ring[Slots], ring_ptr, held_frames;
  path_res_t         expected_paths[$];
  int unsigned       errors = 0, items_sent = 0, idle_pct = 29;
  longint unsigned   cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

  // Advance the predictor by one pixel; returns 1 at a frame end.
  function automatic bit predict_pixel(logic [15:0] d, output path_res_t res);
    int unsigned w, h;
    longint unsigned c[3], sq, df;
    w = clamp_dim(cfg_w, dcpl_pkg::MaxWidth);
    h = clamp_dim(cfg_h, dcpl_pkg::MaxHeight);
    res = '0;
    if (d != 0) begin
      s_col += col;
      s_row += row;
      s_dep += d;
      n_pix++;
    end
    if (col + 1 < w) begin
      col++;
      return 0;
    end
    col = 0;
    if (row + 1 < h) begin
      row++;
      return 0;
    end
    row = 0;
    c = '{0, 0, 0};
    if (n_pix != 0) begin
      c[0] = (s_col << 8) / n_pix;
      c[1] = (s_row << 8) / n_pix;
      c[2] = (s_dep << 8) / (n_pix * dcpl_pkg::DepthScale);
    end
    if (held_frames >= 1) begin
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        df = (c[k] >= prev_c[k]) ? c[k] - prev_c[k] : prev_c[k] - c[k];
        sq += df * df;
      end
      if (held_frames - 1 >= Slots) run_sum -= ring[ring_ptr];
      ring[ring_ptr] = 32'(int_sqrt(sq));
      run_sum += ring[ring_ptr];
      ring_ptr = (ring_ptr + 1 >= Slots) ? 0 : ring_ptr + 1;
    end
    if (held_frames < dcpl_pkg::WindowFrames) held_frames++;
    prev_c = c;
    s_col = 0; s_row = 0; s_dep = 0; n_pix = 0;
    res.displacement = (held_frames >= 2)
        ? dcpl_pkg::DispW'((run_sum > dcpl_pkg::DispMax) ? dcpl_pkg::DispMax : run_sum) : '0;
    res.frames = held_frames[3:0];
    return 1;
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [dcpl_pkg::CfgIdxW-1:0] idx,
                           logic [dcpl_pkg::CfgDataW-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.data  = {idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == dcpl_pkg::RegFrameWidth) cfg_w = val;
    else cfg_h = val;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Drive one pixel request; on acceptance the predictor advances and a frame end queues its expectation.
  task automatic send_pixel(logic [15:0] d, bit typed = 0,
                            logic [dcpl_pkg::DispW-1:0] t_disp = '0,
                            logic [3:0] t_frames = '0);
    path_res_t r;
    idle_gap();
    in_if.valid = 1'b1;
    in_if.data  = d;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (predict_pixel(d, r)) begin
      if (typed) begin
        r.displacement = t_disp;
        r.frames = t_frames;
      end
      expected_paths = {expected_paths, r};
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic settle();
    while (expected_paths.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_depth();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return 16'd0;
    if (p < 40) return 16'hFFFF;
    if (p < 45) return 16'd1;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    path_res_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_paths.size() == 0) begin
        $error("result without request: displacement %0d frames %0d",
               got.displacement, got.frames);
        errors++;
      end else begin
        want = expected_paths.pop_front();
        if (got.displacement !== want.displacement) begin
          $error("displacement expected %0d actual %0d", want.displacement, got.displacement);
          errors++;
        end
        if (got.frames !== want.frames) begin
          $error("frames_in_window expected %0d actual %0d", want.frames, got.frames);
          errors++;
        end
      end
    end
  end

  pixel_row_t one_pixel_frames[13] = '{
    '{16'h0000, 1, 22'd0, 4'd1},   // first frame, empty: no distance yet
    '{16'hFFFF, 0, 22'd0, 4'd0},
    '{16'h0000, 0, 22'd0, 4'd0},
    '{16'h0001, 0, 22'd0, 4'd0},
    '{16'h0064, 0, 22'd0, 4'd0},
    '{16'hFFFF, 0, 22'd0, 4'd0},
    '{16'h8000, 0, 22'd0, 4'd0},
    '{16'h7FFF, 0, 22'd0, 4'd0},
    '{16'h0000, 0, 22'd0, 4'd0},
    '{16'hFFFF, 0, 22'd0, 4'd0},
    '{16'h0000, 0, 22'd0, 4'd0},   // window full from here, oldest drops
    '{16'hFFFF, 0, 22'd0, 4'd0},
    '{16'h5555, 0, 22'd0, 4'd0}
  };

  initial begin
    int unsigned n;
    cfg_w = dcpl_pkg::ResetWidth; cfg_h = dcpl_pkg::ResetHeight;
    col = 0; row = 0; s_col = 0; s_row = 0; s_dep = 0; n_pix = 0;
    prev_c = '{0, 0, 0}; run_sum = 0; ring_ptr = 0; held_frames = 0;
    foreach (ring[i]) ring[i] = 0;
    in_if.valid = 1'b0; in_if.data = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one pixel per frame
    write_reg(dcpl_pkg::RegFrameWidth, 11'd1);
    write_reg(dcpl_pkg::RegFrameHeight, 11'd1);
    foreach (one_pixel_frames[i])
      send_pixel(one_pixel_frames[i].depth, one_pixel_frames[i].typed,
                 one_pixel_frames[i].disp, one_pixel_frames[i].frames);
    settle();
    // zero size acts as one
    write_reg(dcpl_pkg::RegFrameWidth, 11'd0);
    write_reg(dcpl_pkg::RegFrameHeight, 11'd0);
    repeat (3) send_pixel(rand_depth());
    settle();
    // size change in the middle of a frame
    write_reg(dcpl_pkg::RegFrameWidth, 11'd4);
    write_reg(dcpl_pkg::RegFrameHeight, 11'd4);
    repeat (6) send_pixel(rand_depth());
    settle();
    write_reg(dcpl_pkg::RegFrameWidth, 11'd1);
    write_reg(dcpl_pkg::RegFrameHeight, 11'd2);
    repeat (4) send_pixel(rand_depth());
    settle();

    items_sent = 0;
    for (int ph = 0; items_sent < 600; ph++) begin
      idle_pct = (ph == 3) ? 0 : 29;
      if ($urandom_range(9) == 0) begin
        write_reg(dcpl_pkg::RegFrameWidth, 11'($urandom_range(40)));
        write_reg(dcpl_pkg::RegFrameHeight, 11'($urandom_range(3)));
      end else begin
        write_reg(dcpl_pkg::RegFrameWidth, 11'($urandom_range(1, 6)));
        write_reg(dcpl_pkg::RegFrameHeight, 11'($urandom_range(1, 4)));
      end
      n = $urandom_range(20, 80);
      repeat (n) send_pixel(rand_depth());
      settle();
    end
    idle_pct = 29;

    if (errors == 0 && expected_paths.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (expected_paths.size() != 0)
        $error("%0d expected results never arrived", expected_paths.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[depth_centroid_path_length_core.f]
+incdir+design
design/dcpl_pkg.sv
design/dcpl_if.sv
design/dcpl_front.sv
design/dcpl_fifo.sv
design/dcpl_back.sv
design/depth_centroid_path_length_core.sv
tb/sv/depth_centroid_path_length_core_tb.sv
